// ===== src/ctse_pkg.sv =====
// Shared types, codes and the month length function for the clock time-set editor.
package ctse_pkg;

  typedef enum logic [2:0] {
    REQ_MODE   = 3'd0,
    REQ_SELECT = 3'd1,
    REQ_UP     = 3'd2,
    REQ_DOWN   = 3'd3,
    REQ_TICK   = 3'd4,
    REQ_LOAD   = 3'd5
  } req_t;

  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;

  localparam logic [6:0] YEAR_MAX   = 7'd99;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;

  localparam logic [15:0] BLINK_PERIOD_RST = 16'd1000;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_time_t;

  typedef struct packed {
    req_t      req;
    cal_time_t ld;
  } in_item_t;

  typedef struct packed {
    cal_time_t  tm;
    logic [2:0] sel;
    logic       editing;
    logic       blank;
    logic       commit;
  } res_item_t;

  function automatic logic [4:0] days_in(input logic [6:0] y, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2: begin
        d = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        d = 5'd30;
      end
      default: begin
        d = 5'd31;
      end
    endcase
    return d;
  endfunction

endpackage

// ===== src/ctse_in_stage.sv =====
// Input register for request items.
module ctse_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctse_pkg::in_item_t in_item,
  input  logic               fire,
  output logic               item_valid,
  output ctse_pkg::in_item_t item
);
  import ctse_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     take;

  assign in_ready   = !valid_r || fire;
  assign take       = in_valid && in_ready;
  assign valid_nxt  = take || (valid_r && !fire);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== src/ctse_core.sv =====
// Editor state registers and next-state logic for one item.
module ctse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  logic                fire,
  input  ctse_pkg::in_item_t  item,
  output ctse_pkg::res_item_t res_nxt
);
  import ctse_pkg::*;

  cal_time_t   time_r, time_nxt;
  logic [2:0]  sel_r, sel_nxt;
  logic        edit_r, edit_nxt;
  logic        blink_r, blink_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] period_r;
  logic [15:0] tick_inc;
  logic        commit;
  logic        sel_ok, up_en, dn_en, ld_en;
  logic [6:0]  yr_nxt;
  logic [3:0]  mo_nxt;
  logic [4:0]  dim;

  assign sel_ok = (sel_r <= FLD_SECOND);
  assign up_en  = (item.req == REQ_UP) && edit_r && sel_ok;
  assign dn_en  = (item.req == REQ_DOWN) && edit_r && sel_ok;
  assign ld_en  = (item.req == REQ_LOAD) && !edit_r;
  assign tick_inc = tick_r + 16'd1;

  // year and month first; day range depends on them
  always_comb begin
    yr_nxt = time_r.year;
    mo_nxt = time_r.month;
    if (ld_en) begin
      yr_nxt = (item.ld.year > YEAR_MAX) ? YEAR_MAX : item.ld.year;
      if (item.ld.month == 4'd0) begin
        mo_nxt = 4'd1;
      end else if (item.ld.month > MONTH_MAX) begin
        mo_nxt = MONTH_MAX;
      end else begin
        mo_nxt = item.ld.month;
      end
    end else if (up_en) begin
      if (sel_r == FLD_YEAR) begin
        yr_nxt = (time_r.year >= YEAR_MAX) ? 7'd0 : time_r.year + 7'd1;
      end
      if (sel_r == FLD_MONTH) begin
        mo_nxt = (time_r.month >= MONTH_MAX) ? 4'd1 : time_r.month + 4'd1;
      end
    end else if (dn_en) begin
      if (sel_r == FLD_YEAR) begin
        yr_nxt = (time_r.year == 7'd0) ? YEAR_MAX : time_r.year - 7'd1;
      end
      if (sel_r == FLD_MONTH) begin
        mo_nxt = (time_r.month <= 4'd1) ? MONTH_MAX : time_r.month - 4'd1;
      end
    end
  end

  assign dim = days_in(yr_nxt, mo_nxt);

  always_comb begin
    time_nxt       = time_r;
    time_nxt.year  = yr_nxt;
    time_nxt.month = mo_nxt;
    sel_nxt        = sel_r;
    edit_nxt       = edit_r;
    blink_nxt      = blink_r;
    tick_nxt       = tick_r;
    commit         = 1'b0;
    case (item.req)
      REQ_MODE: begin
        if (!edit_r) begin
          edit_nxt = 1'b1;
        end else begin
          edit_nxt = 1'b0;
          commit   = 1'b1;
          sel_nxt  = FLD_YEAR;
        end
      end
      REQ_SELECT: begin
        if (edit_r) begin
          sel_nxt = (sel_r >= FLD_SECOND) ? FLD_YEAR : sel_r + 3'd1;
        end
      end
      REQ_UP: begin
        if (up_en) begin
          if (sel_r == FLD_DAY) begin
            time_nxt.day = (time_r.day >= dim) ? 5'd1 : time_r.day + 5'd1;
          end else if (time_r.day > dim) begin
            time_nxt.day = 5'd1;
          end
          if (sel_r == FLD_HOUR) begin
            time_nxt.hour = (time_r.hour >= HOUR_MAX) ? 5'd0 : time_r.hour + 5'd1;
          end
          if (sel_r == FLD_MINUTE) begin
            time_nxt.minute = (time_r.minute >= MINSEC_MAX) ? 6'd0 : time_r.minute + 6'd1;
          end
          if (sel_r == FLD_SECOND) begin
            time_nxt.second = (time_r.second >= MINSEC_MAX) ? 6'd0 : time_r.second + 6'd1;
          end
        end
      end
      REQ_DOWN: begin
        if (dn_en) begin
          if (sel_r == FLD_DAY) begin
            if (time_r.day <= 5'd1 || (time_r.day - 5'd1) > dim) begin
              time_nxt.day = dim;
            end else begin
              time_nxt.day = time_r.day - 5'd1;
            end
          end else if (time_r.day == 5'd0 || time_r.day > dim) begin
            time_nxt.day = dim;
          end
          if (sel_r == FLD_HOUR) begin
            time_nxt.hour = (time_r.hour == 5'd0) ? HOUR_MAX : time_r.hour - 5'd1;
          end
          if (sel_r == FLD_MINUTE) begin
            time_nxt.minute = (time_r.minute == 6'd0) ? MINSEC_MAX : time_r.minute - 6'd1;
          end
          if (sel_r == FLD_SECOND) begin
            time_nxt.second = (time_r.second == 6'd0) ? MINSEC_MAX : time_r.second - 6'd1;
          end
        end
      end
      REQ_TICK: begin
        if (tick_inc >= period_r) begin
          tick_nxt  = 16'd0;
          blink_nxt = !blink_r;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      REQ_LOAD: begin
        if (ld_en) begin
          if (item.ld.day == 5'd0) begin
            time_nxt.day = 5'd1;
          end else if (item.ld.day > dim) begin
            time_nxt.day = dim;
          end else begin
            time_nxt.day = item.ld.day;
          end
          time_nxt.hour   = (item.ld.hour > HOUR_MAX) ? HOUR_MAX : item.ld.hour;
          time_nxt.minute = (item.ld.minute > MINSEC_MAX) ? MINSEC_MAX : item.ld.minute;
          time_nxt.second = (item.ld.second > MINSEC_MAX) ? MINSEC_MAX : item.ld.second;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_nxt.tm      = time_nxt;
  assign res_nxt.sel     = sel_nxt;
  assign res_nxt.editing = edit_nxt;
  assign res_nxt.blank   = edit_nxt && blink_nxt;
  assign res_nxt.commit  = commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r   <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0,
                    second: 6'd0};
      sel_r    <= FLD_YEAR;
      edit_r   <= 1'b0;
      blink_r  <= 1'b0;
      tick_r   <= 16'd0;
      period_r <= BLINK_PERIOD_RST;
    end else begin
      if (fire) begin
        time_r  <= time_nxt;
        sel_r   <= sel_nxt;
        edit_r  <= edit_nxt;
        blink_r <= blink_nxt;
        tick_r  <= tick_nxt;
      end
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
    end
  end

`ifndef SYNTHESIS
  a_commit_exit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.commit |=> !edit_r && (sel_r == FLD_YEAR))
    else $error("commit without leaving edit mode");
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.month != 4'd0) && (time_r.month <= MONTH_MAX))
    else $error("month out of range");
  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (time_r.day != 5'd0) && (time_r.day <= days_in(time_r.year, time_r.month)))
    else $error("day out of range");
  a_view_sel: assert property (@(posedge clk) disable iff (!rst_n)
    !edit_r |-> (sel_r == FLD_YEAR))
    else $error("selection moved in view mode");
  a_blink_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item.req != REQ_TICK) |=> $stable(blink_r))
    else $error("blink phase changed without tick");
`endif

endmodule

// ===== src/ctse_out_stage.sv =====
// Result register for the output channel.
module ctse_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ctse_pkg::res_item_t res_nxt,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                busy,
  output ctse_pkg::res_item_t res
);
  import ctse_pkg::*;

  logic      valid_r, valid_nxt;
  res_item_t res_r;

  assign valid_nxt = fire || (valid_r && !out_ready);
  assign busy      = valid_r && !out_ready;
  assign out_valid = valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/clock_time_set_editor.sv =====
// Top level of the calendar clock time-set editor.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_ready    req_type, load_year .. load_second
//  out_      output     out_valid/out_ready  time fields, selected_field, flags
//  cfg_      input      cfg_we               cfg_wdata (blink half period)
//
// One item per cycle while the result register is not stalled: an item is held in the
// input register, then the edit logic updates the state and fills the result register.
// An accepted item passes the input register and then the result register before out_valid.
// A stalled result holds the input register; in_ready falls only when both hold items.
// Synchronous active-low reset returns the time to year 0, January 1st, 00:00:00.
module clock_time_set_editor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [6:0]  in_load_year,
  input  logic [3:0]  in_load_month,
  input  logic [4:0]  in_load_day,
  input  logic [4:0]  in_load_hour,
  input  logic [5:0]  in_load_minute,
  input  logic [5:0]  in_load_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_selected_field,
  output logic        out_editing,
  output logic        out_blank_selected,
  output logic        out_commit,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import ctse_pkg::*;

  in_item_t  in_item, item;
  res_item_t res_nxt, res;
  logic      item_valid, fire, out_busy;

  assign in_item.req       = req_t'(in_req_type);
  assign in_item.ld.year   = in_load_year;
  assign in_item.ld.month  = in_load_month;
  assign in_item.ld.day    = in_load_day;
  assign in_item.ld.hour   = in_load_hour;
  assign in_item.ld.minute = in_load_minute;
  assign in_item.ld.second = in_load_second;

  assign fire = item_valid && !out_busy;

  ctse_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  ctse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res_nxt   (res_nxt)
  );

  ctse_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_nxt   (res_nxt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .busy      (out_busy),
    .res       (res)
  );

  assign out_year           = res.tm.year;
  assign out_month          = res.tm.month;
  assign out_day            = res.tm.day;
  assign out_hour           = res.tm.hour;
  assign out_minute         = res.tm.minute;
  assign out_second         = res.tm.second;
  assign out_selected_field = res.sel;
  assign out_editing        = res.editing;
  assign out_blank_selected = res.blank;
  assign out_commit         = res.commit;

endmodule

// ===== sim/tb_clock_time_set_editor.sv =====
// Self-checking testbench for the clock time-set editor: directed table, then random items.
module tb_clock_time_set_editor;
  import ctse_pkg::*;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int WRAP_MARK = 1000;
  localparam int PHASE_ITEMS = 115;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [2:0] req;
    cal_time_t  ld;
    logic       typed;
    res_item_t  res;
  } dir_row_t;

  localparam cal_time_t NO_LD = '0;
  localparam res_item_t NO_RES = '0;
  localparam cal_time_t T_RST = '{7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
  localparam cal_time_t T_FEB = '{7'd1, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = 3'd0;
  logic [6:0]  in_load_year = 7'd0;
  logic [3:0]  in_load_month = 4'd0;
  logic [4:0]  in_load_day = 5'd0;
  logic [4:0]  in_load_hour = 5'd0;
  logic [5:0]  in_load_minute = 6'd0;
  logic [5:0]  in_load_second = 6'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_selected_field;
  logic        out_editing;
  logic        out_blank_selected;
  logic        out_commit;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  clock_time_set_editor i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_load_year       (in_load_year),
    .in_load_month      (in_load_month),
    .in_load_day        (in_load_day),
    .in_load_hour       (in_load_hour),
    .in_load_minute     (in_load_minute),
    .in_load_second     (in_load_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_year           (out_year),
    .out_month          (out_month),
    .out_day            (out_day),
    .out_hour           (out_hour),
    .out_minute         (out_minute),
    .out_second         (out_second),
    .out_selected_field (out_selected_field),
    .out_editing        (out_editing),
    .out_blank_selected (out_blank_selected),
    .out_commit         (out_commit),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb_clock_time_set_editor: errors");
    $finish;
  end

  // predictor state
  int        m_year, m_month, m_day, m_hour, m_minute, m_second;
  int        m_sel, m_ticks;
  bit        m_edit, m_blink;
  int        blink_period;

  res_item_t disp_q[$];
  int        mismatch_cnt = 0;
  bit        gaps_on = 1'b1;
  int        hold_tokens = 0;
  int        hold_done = 0;
  int        stall_left = 0;
  int        run_left = 0;

  dir_row_t dir_tab [26] = '{
    '{REQ_TICK,    NO_LD, 1'b1, '{T_RST, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SPARE_A, NO_LD, 1'b1, '{T_RST, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SELECT,  NO_LD, 1'b1, '{T_RST, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_UP,      NO_LD, 1'b1, '{T_RST, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_LOAD, '{7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b1,
      '{'{7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_LOAD, NO_LD, 1'b1, '{T_RST, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_LOAD, '{7'd0, 4'd2, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1,
      '{'{7'd0, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59}, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_LOAD, '{7'd1, 4'd2, 5'd30, 5'd0, 6'd0, 6'd0}, 1'b1,
      '{T_FEB, 3'd0, 1'b0, 1'b0, 1'b0}},
    '{REQ_MODE, NO_LD, 1'b1, '{T_FEB, 3'd0, 1'b1, 1'b0, 1'b0}},
    '{REQ_LOAD, '{7'd50, 4'd6, 5'd15, 5'd12, 6'd30, 6'd30}, 1'b1,
      '{T_FEB, 3'd0, 1'b1, 1'b0, 1'b0}},
    '{REQ_DOWN,   NO_LD, 1'b0, NO_RES},
    '{REQ_DOWN,   NO_LD, 1'b0, NO_RES},
    '{REQ_UP,     NO_LD, 1'b0, NO_RES},
    '{REQ_SELECT, NO_LD, 1'b0, NO_RES},
    '{REQ_DOWN,   NO_LD, 1'b0, NO_RES},
    '{REQ_DOWN,   NO_LD, 1'b0, NO_RES},
    '{REQ_UP,     NO_LD, 1'b0, NO_RES},
    '{REQ_SELECT, NO_LD, 1'b0, NO_RES},
    '{REQ_DOWN,   NO_LD, 1'b0, NO_RES},
    '{REQ_SELECT, NO_LD, 1'b0, NO_RES},
    '{REQ_DOWN,   NO_LD, 1'b0, NO_RES},
    '{REQ_SELECT, NO_LD, 1'b0, NO_RES},
    '{REQ_SELECT, NO_LD, 1'b0, NO_RES},
    '{REQ_DOWN,   NO_LD, 1'b0, NO_RES},
    '{REQ_SELECT, NO_LD, 1'b0, NO_RES},
    '{REQ_MODE,   NO_LD, 1'b0, NO_RES}
  };

  logic [15:0] blink_periods [8] = '{16'd0, 16'd1, 16'd2, 16'd65535,
                                     16'd3, 16'd5, 16'd17, 16'd1};

  function automatic int month_days(int y, int m);
    if (m < 1 || m > 12) return 31;
    if (m == 2) return (y % 4 == 0) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  task automatic reset_model();
    m_year = 0;
    m_month = 1;
    m_day = 1;
    m_hour = 0;
    m_minute = 0;
    m_second = 0;
    m_sel = 0;
    m_edit = 1'b0;
    m_blink = 1'b0;
    m_ticks = 0;
    blink_period = int'(BLINK_PERIOD_RST);
  endtask

  function automatic res_item_t next_display(logic [2:0] req, cal_time_t ld);
    res_item_t r;
    bit        cm;
    int        dim;
    cm = 1'b0;
    case (req)
      REQ_MODE: begin
        if (!m_edit) begin
          m_edit = 1'b1;
        end else begin
          m_edit = 1'b0;
          cm = 1'b1;
          m_sel = 0;
        end
      end
      REQ_SELECT: begin
        if (m_edit) m_sel = (m_sel >= 5) ? 0 : m_sel + 1;
      end
      REQ_UP: begin
        if (m_edit && m_sel <= 5) begin
          case (m_sel)
            FLD_YEAR:   m_year++;
            FLD_MONTH:  m_month++;
            FLD_DAY:    m_day++;
            FLD_HOUR:   m_hour++;
            FLD_MINUTE: m_minute++;
            default:    m_second++;
          endcase
          if (m_year > YEAR_MAX) m_year = 0;
          if (m_month > MONTH_MAX) m_month = 1;
          if (m_day > month_days(m_year, m_month)) m_day = 1;
          if (m_hour > HOUR_MAX) m_hour = 0;
          if (m_minute > MINSEC_MAX) m_minute = 0;
          if (m_second > MINSEC_MAX) m_second = 0;
        end
      end
      REQ_DOWN: begin
        if (m_edit && m_sel <= 5) begin
          // a field at zero goes to a marker above every range, then wraps
          case (m_sel)
            FLD_YEAR:   m_year = (m_year == 0) ? WRAP_MARK : m_year - 1;
            FLD_MONTH:  m_month = (m_month == 0) ? WRAP_MARK : m_month - 1;
            FLD_DAY:    m_day = (m_day == 0) ? WRAP_MARK : m_day - 1;
            FLD_HOUR:   m_hour = (m_hour == 0) ? WRAP_MARK : m_hour - 1;
            FLD_MINUTE: m_minute = (m_minute == 0) ? WRAP_MARK : m_minute - 1;
            default:    m_second = (m_second == 0) ? WRAP_MARK : m_second - 1;
          endcase
          if (m_year > 100) m_year = int'(YEAR_MAX);
          if (m_month == 0 || m_month > 100) m_month = int'(MONTH_MAX);
          dim = month_days(m_year, m_month);
          if (m_day > dim || m_day == 0) m_day = dim;
          if (m_hour > 100) m_hour = int'(HOUR_MAX);
          if (m_minute > 100) m_minute = int'(MINSEC_MAX);
          if (m_second > 100) m_second = int'(MINSEC_MAX);
        end
      end
      REQ_TICK: begin
        m_ticks = (m_ticks + 1) & 16'hFFFF;
        if (m_ticks >= blink_period) begin
          m_ticks = 0;
          m_blink = ~m_blink;
        end
      end
      REQ_LOAD: begin
        if (!m_edit) begin
          m_year = int'(ld.year);
          m_month = int'(ld.month);
          m_day = int'(ld.day);
          m_hour = int'(ld.hour);
          m_minute = int'(ld.minute);
          m_second = int'(ld.second);
          if (m_year > YEAR_MAX) m_year = int'(YEAR_MAX);
          if (m_month == 0) m_month = 1;
          if (m_month > MONTH_MAX) m_month = int'(MONTH_MAX);
          dim = month_days(m_year, m_month);
          if (m_day == 0) m_day = 1;
          if (m_day > dim) m_day = dim;
          if (m_hour > HOUR_MAX) m_hour = int'(HOUR_MAX);
          if (m_minute > MINSEC_MAX) m_minute = int'(MINSEC_MAX);
          if (m_second > MINSEC_MAX) m_second = int'(MINSEC_MAX);
        end
      end
      default: begin
      end
    endcase
    r.tm.year = m_year[6:0];
    r.tm.month = m_month[3:0];
    r.tm.day = m_day[4:0];
    r.tm.hour = m_hour[4:0];
    r.tm.minute = m_minute[5:0];
    r.tm.second = m_second[5:0];
    r.sel = m_sel[2:0];
    r.editing = m_edit;
    r.blank = m_edit & m_blink;
    r.commit = cm;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic send_item(logic [2:0] req, cal_time_t ld, logic typed, res_item_t typed_res);
    res_item_t pred;
    int        g;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_load_year <= ld.year;
    in_load_month <= ld.month;
    in_load_day <= ld.day;
    in_load_hour <= ld.hour;
    in_load_minute <= ld.minute;
    in_load_second <= ld.second;
    do @(posedge clk); while (!in_ready);
    pred = next_display(req, ld);
    disp_q.push_back(typed ? typed_res : pred);
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (disp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_period(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    blink_period = int'(v);
  endtask

  task automatic rand_item(output logic [2:0] req, output cal_time_t ld);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) req = REQ_MODE;
    else if (r < 23) req = REQ_SELECT;
    else if (r < 48) req = REQ_UP;
    else if (r < 73) req = REQ_DOWN;
    else if (r < 88) req = REQ_TICK;
    else if (r < 98) req = REQ_LOAD;
    else req = (r == 98) ? REQ_SPARE_A : REQ_SPARE_B;
    if ($urandom_range(0, 1) == 0) begin
      ld.year = 7'($urandom_range(0, 99));
      ld.month = 4'($urandom_range(1, 12));
      ld.day = 5'($urandom_range(1, 31));
      ld.hour = 5'($urandom_range(0, 23));
      ld.minute = 6'($urandom_range(0, 59));
      ld.second = 6'($urandom_range(0, 59));
    end else begin
      ld = {$urandom, 1'($urandom)};
    end
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (disp_q.size() == 0) begin
        $error("result item with nothing expected");
        mismatch_cnt++;
      end else begin
        want = disp_q.pop_front();
        cmp_field("year", int'(want.tm.year), int'(out_year));
        cmp_field("month", int'(want.tm.month), int'(out_month));
        cmp_field("day", int'(want.tm.day), int'(out_day));
        cmp_field("hour", int'(want.tm.hour), int'(out_hour));
        cmp_field("minute", int'(want.tm.minute), int'(out_minute));
        cmp_field("second", int'(want.tm.second), int'(out_second));
        cmp_field("selected_field", int'(want.sel), int'(out_selected_field));
        cmp_field("editing", int'(want.editing), int'(out_editing));
        cmp_field("blank_selected", int'(want.blank), int'(out_blank_selected));
        cmp_field("commit", int'(want.commit), int'(out_commit));
      end
    end
    if (hold_done != hold_tokens) begin
      hold_done = hold_tokens;
      stall_left = LONG_HOLD;
      run_left = 0;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left--;
    end else begin
      out_ready <= 1'b1;
      run_left = $urandom_range(0, 20);
      stall_left = pick_gap();
    end
  end

  initial begin
    logic [2:0] rq;
    cal_time_t  ld;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].req, dir_tab[i].ld, dir_tab[i].typed, dir_tab[i].res);
    end
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      set_period((ph == 6) ? 16'($urandom_range(4, 40)) : blink_periods[ph]);
      gaps_on = (ph != 4);
      if (ph == 2) begin
        // receiver stalls while items keep coming back to back
        hold_tokens++;
        gaps_on = 1'b0;
        repeat (30) begin
          rand_item(rq, ld);
          send_item(rq, ld, 1'b0, NO_RES);
        end
        gaps_on = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        rand_item(rq, ld);
        send_item(rq, ld, 1'b0, NO_RES);
      end
      drain();
    end
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && disp_q.size() == 0) begin
      $display("tb_clock_time_set_editor: clean");
    end else begin
      $display("tb_clock_time_set_editor: errors");
    end
    $finish;
  end

endmodule
